### rtl/pcm_frame_to_mono_int16_unit_macros.svh
// Assertion macros shared by the RTL; clk and arst_n must be in scope.
`ifndef PCM_FRAME_TO_MONO_INT16_UNIT_MACROS_SVH
`define PCM_FRAME_TO_MONO_INT16_UNIT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next.
`define PCMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PCMM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/pcmm_pkg.sv
`default_nettype none
package pcmm_pkg;
	localparam int unsigned FMT_W    = 3;
	localparam int unsigned CNT_W    = 3;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 3;
	localparam int unsigned RAW_W    = 32;
	localparam int unsigned SMP_W    = 16;

	localparam logic [FMT_W-1:0] FMT_UNKNOWN = 3'd0;
	localparam logic [FMT_W-1:0] FMT_U8      = 3'd1;
	localparam logic [FMT_W-1:0] FMT_S16     = 3'd2;
	localparam logic [FMT_W-1:0] FMT_S32     = 3'd3;
	localparam logic [FMT_W-1:0] FMT_F32     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

	localparam logic [FMT_W-1:0] RST_FORMAT = FMT_S16;
	localparam logic [CNT_W-1:0] RST_COUNT  = 3'd1;

	localparam logic [14:0] FULL_SCALE = 15'd32767;

	typedef enum logic [1:0] {
		KIND_DIRECT = 2'd0,
		KIND_ZERO   = 2'd1,
		KIND_SAT    = 2'd2,
		KIND_NORM   = 2'd3
	} kind_t;
endpackage
`default_nettype wire

### rtl/pcmm_in_if.sv
`default_nettype none
interface pcmm_in_if;
	import pcmm_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] left_raw;
	logic [RAW_W-1:0] right_raw;
	modport source (output valid, left_raw, right_raw, input ready);
	modport sink   (input valid, left_raw, right_raw, output ready);
endinterface
`default_nettype wire

### rtl/pcmm_out_if.sv
`default_nettype none
interface pcmm_out_if;
	import pcmm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [SMP_W-1:0]  mono_sample;
	modport source (output valid, mono_sample, input ready);
	modport sink   (input valid, mono_sample, output ready);
endinterface
`default_nettype wire

### rtl/pcmm_chan_conv.sv
`default_nettype none
// Three-stage conversion of one channel word to a signed 16-bit sample.
module pcmm_chan_conv
	import pcmm_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [FMT_W-1:0]        fmt,
	input  wire logic [RAW_W-1:0]        raw,
	output logic signed [SMP_W-1:0]      sample
);
	// stage 1: decode, mantissa times full scale
	kind_t              kind_d;
	logic [SMP_W-1:0]   direct_d;
	logic [4:0]         kb_d;
	logic [7:0]         expo;
	logic [22:0]        man;

	kind_t              kind_s1;
	logic               sign_s1;
	logic [SMP_W-1:0]   direct_s1;
	logic [38:0]        prod_s1;
	logic [4:0]         kb_s1;

	assign expo = raw[30:23];
	assign man  = raw[22:0];

	always_comb begin
		kind_d   = KIND_DIRECT;
		direct_d = raw[15:0];
		kb_d     = 5'(8'd127 - expo);
		case (fmt)
			FMT_U8: begin
				direct_d = {~raw[7], raw[6:0], 8'h00};
			end
			FMT_S16: begin
				direct_d = raw[15:0];
			end
			FMT_S32: begin
				direct_d = raw[31:16];
			end
			default: begin
				if (expo == 8'hFF && man != 23'd0)
					kind_d = KIND_ZERO;
				else if (expo >= 8'd127)
					kind_d = KIND_SAT;
				else if (expo < 8'd100)
					kind_d = KIND_ZERO;
				else
					kind_d = KIND_NORM;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= kind_d;
			sign_s1   <= raw[31];
			direct_s1 <= direct_d;
			prod_s1   <= {1'b1, man} * FULL_SCALE;
			kb_s1     <= kb_d;
		end
	end

	// stage 2: round the product to single precision
	logic [23:0] mant_c;
	logic        grd_c;
	logic        stk_c;
	logic [5:0]  k_c;

	kind_t              kind_s2;
	logic               sign_s2;
	logic [SMP_W-1:0]   direct_s2;
	logic [24:0]        r_s2;
	logic [5:0]         k_s2;

	always_comb begin
		if (prod_s1[38]) begin
			mant_c = prod_s1[38:15];
			grd_c  = prod_s1[14];
			stk_c  = |prod_s1[13:0];
			k_c    = 6'({1'b0, kb_s1} + 6'd8);
		end else begin
			mant_c = prod_s1[37:14];
			grd_c  = prod_s1[13];
			stk_c  = |prod_s1[12:0];
			k_c    = 6'({1'b0, kb_s1} + 6'd9);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2   <= kind_s1;
			sign_s2   <= sign_s1;
			direct_s2 <= direct_s1;
			r_s2      <= {1'b0, mant_c} + 25'(grd_c & (stk_c | mant_c[0]));
			k_s2      <= k_c;
		end
	end

	// stage 3: round to integer, ties to even, and select the result
	logic [50:0] shf;
	logic [14:0] q;
	logic [14:0] mag;
	logic signed [SMP_W-1:0] res_c;

	assign shf = {r_s2, 26'd0} >> k_s2;
	assign q   = shf[40:26];
	assign mag = q + 15'(shf[25] & ((|shf[24:0]) | q[0]));

	always_comb begin
		case (kind_s2)
			KIND_DIRECT: res_c = direct_s2;
			KIND_ZERO:   res_c = '0;
			KIND_SAT:    res_c = sign_s2 ? -$signed({1'b0, FULL_SCALE})
			                             : $signed({1'b0, FULL_SCALE});
			KIND_NORM:   res_c = sign_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			default:     res_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			sample <= res_c;
	end
endmodule
`default_nettype wire

### rtl/pcm_frame_to_mono_int16_unit.sv
`default_nettype none
// PCM frame to mono int16 converter. Each accepted item is one frame (left and
// right raw words); it yields one signed 16-bit mono sample, and one frame can
// be accepted every cycle while the output is not held. The stages follow the
// float path: decode and mantissa multiply, rounding to single precision,
// rounding to integer, then the stereo sum and halving in the output register.
// The whole pipeline advances together; when the output is held the input is
// stalled. Frames taken while the format is unknown or the channel count is
// not one or two give no result. Configure only while the block is idle.
module pcm_frame_to_mono_int16_unit
	import pcmm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_data,
	pcmm_in_if.sink                    in_item,
	pcmm_out_if.source                 out_item
);
	logic [FMT_W-1:0] fmt_q;
	logic [CNT_W-1:0] cnt_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= RST_FORMAT;
			cnt_q <= RST_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_FORMAT: fmt_q <= cfg_data;
				REG_CHANNEL_COUNT: cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic take;
	logic cfg_ok;
	logic v_s1, v_s2, v_s3, v_s4;
	logic two_s1, two_s2, two_s3;
	logic signed [SMP_W-1:0] left_smp;
	logic signed [SMP_W-1:0] right_smp;
	logic signed [SMP_W-1:0] mono_s4;

	// advance everything unless a finished sample is being held
	assign en     = !v_s4 || out_item.ready;
	assign take   = in_item.valid && en;
	assign cfg_ok = (fmt_q == FMT_U8 || fmt_q == FMT_S16 || fmt_q == FMT_S32 ||
	                 fmt_q == FMT_F32) && (cnt_q == 3'd1 || cnt_q == 3'd2);

	assign in_item.ready = en;

	pcmm_chan_conv u_left (
		.clk    (clk),
		.en     (en),
		.fmt    (fmt_q),
		.raw    (in_item.left_raw),
		.sample (left_smp)
	);

	pcmm_chan_conv u_right (
		.clk    (clk),
		.en     (en),
		.fmt    (fmt_q),
		.raw    (in_item.right_raw),
		.sample (right_smp)
	);

	// valid bits travel with the data; drop items under a bad configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= take && cfg_ok;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			two_s1 <= (cnt_q == 3'd2);
			two_s2 <= two_s1;
			two_s3 <= two_s2;
		end
	end

	// downmix: sum and halve, truncating toward zero
	logic signed [SMP_W:0] sum_c;
	logic signed [SMP_W:0] adj_c;

	assign sum_c = two_s3 ? (SMP_W+1)'(left_smp) + (SMP_W+1)'(right_smp)
	                      : (SMP_W+1)'(left_smp);
	assign adj_c = sum_c + (SMP_W+1)'(sum_c[SMP_W]);

	always_ff @(posedge clk) begin
		if (en)
			mono_s4 <= two_s3 ? SMP_W'(adj_c >>> 1) : left_smp;
	end

	assign out_item.valid       = v_s4;
	assign out_item.mono_sample = mono_s4;

	`include "pcm_frame_to_mono_int16_unit_macros.svh"

	`PCMM_ASSERT_NEXT(a_bad_cfg_drop, take && !cfg_ok, !v_s1, "item entered under bad config")
	`PCMM_ASSERT_NEXT(a_stall_hold, v_s1 && !en, v_s1, "stage 1 item lost in stall")
	`PCMM_ASSERT_NEXT(a_s3_to_out, v_s3 && en, v_s4, "stage 3 item did not reach output")
	`PCMM_ASSERT_SAME(a_no_take_full, v_s4 && !out_item.ready, !in_item.ready,
		"input taken while output held")
endmodule
`default_nettype wire
